>>> sv/ptad_pkg.sv
// Shared types and constants of the path turn angle and distance unit.
// Holds operation codes, fixed field widths and the CORDIC arctangent table.
// No dependencies.
`timescale 1ns / 1ps

package ptad_pkg;

    localparam logic [1:0] OP_HEADING = 2'd0;
    localparam logic [1:0] OP_TURN    = 2'd1;
    localparam logic [1:0] OP_DIST    = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;

    localparam int ANGLE_W      = 15;
    localparam int LEN_W        = 13;
    localparam int CORDIC_STEPS = 27;
    localparam int ZSCALE_BITS  = 20;
    localparam int NORM_BITS    = 41;
    localparam int NORM_STAGES  = 3;
    localparam int ATAN_W       = 27;

    typedef struct packed {
        logic [1:0] op;
        logic       degen;
    } t_ctl;

    // Arctangent of 2^-idx in units of 2^-20 degree.
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        begin
            case (idx)
                5'd0:    v = 27'd47185920;
                5'd1:    v = 27'd27855475;
                5'd2:    v = 27'd14718068;
                5'd3:    v = 27'd7471121;
                5'd4:    v = 27'd3750058;
                5'd5:    v = 27'd1876857;
                5'd6:    v = 27'd938658;
                5'd7:    v = 27'd469357;
                5'd8:    v = 27'd234682;
                5'd9:    v = 27'd117342;
                5'd10:   v = 27'd58671;
                5'd11:   v = 27'd29335;
                5'd12:   v = 27'd14668;
                5'd13:   v = 27'd7334;
                5'd14:   v = 27'd3667;
                5'd15:   v = 27'd1833;
                5'd16:   v = 27'd917;
                5'd17:   v = 27'd458;
                5'd18:   v = 27'd229;
                5'd19:   v = 27'd115;
                5'd20:   v = 27'd57;
                5'd21:   v = 27'd29;
                5'd22:   v = 27'd14;
                5'd23:   v = 27'd7;
                5'd24:   v = 27'd4;
                5'd25:   v = 27'd2;
                5'd26:   v = 27'd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

>>> sv/ptad_front.sv
// Front end: accepts transactions, forms the difference vectors and the
// cross and dot products, and flags degenerate turns. Depends on ptad_pkg.
`timescale 1ns / 1ps

module ptad_front
    import ptad_pkg::*;
#(
    parameter int COORD_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [1:0]                      i_op,
    input  logic signed [COORD_BITS-1:0]    i_a_x,
    input  logic signed [COORD_BITS-1:0]    i_a_y,
    input  logic signed [COORD_BITS-1:0]    i_b_x,
    input  logic signed [COORD_BITS-1:0]    i_b_y,
    input  logic signed [COORD_BITS-1:0]    i_c_x,
    input  logic signed [COORD_BITS-1:0]    i_c_y,
    input  logic                            i_full,
    output logic                            o_push,
    output logic signed [2*COORD_BITS+1:0]  o_x,
    output logic signed [2*COORD_BITS+1:0]  o_y,
    output t_ctl                            o_ctl
);

    localparam int DW = COORD_BITS + 1;
    localparam int VW = 2 * COORD_BITS + 2;

    logic s1_ready, s2_ready, accept;
    logic r_s1_v, r_s2_v;
    logic [1:0] r_op1;
    logic signed [DW-1:0] r_ux, r_uy, r_vx, r_vy;
    logic signed [DW-1:0] n_ux, n_uy, n_vx, n_vy;
    logic signed [VW-1:0] cr, dt, n_x, n_y;
    logic signed [VW-1:0] r_x, r_y;
    t_ctl n_ctl, r_ctl;

    assign s2_ready = !r_s2_v || !i_full;
    assign s1_ready = !r_s1_v || s2_ready;
    assign accept   = i_start && s1_ready;
    assign o_busy   = !s1_ready;
    assign o_push   = r_s2_v && !i_full;
    assign o_x      = r_x;
    assign o_y      = r_y;
    assign o_ctl    = r_ctl;

    always_comb begin
        n_vx = DW'(i_c_x) - DW'(i_b_x);
        n_vy = DW'(i_c_y) - DW'(i_b_y);
        if (i_op == OP_DIST) begin
            n_ux = n_vx;
            n_uy = n_vy;
        end else begin
            n_ux = DW'(i_b_x) - DW'(i_a_x);
            n_uy = DW'(i_b_y) - DW'(i_a_y);
        end
    end

    always_comb begin
        cr = VW'(r_ux) * VW'(r_vy) - VW'(r_uy) * VW'(r_vx);
        dt = VW'(r_ux) * VW'(r_vx) + VW'(r_uy) * VW'(r_vy);
        if (r_op1 == OP_HEADING) begin
            n_x = VW'(r_ux);
            n_y = VW'(r_uy);
        end else begin
            n_x = dt;
            n_y = cr;
        end
        n_ctl.op    = r_op1;
        n_ctl.degen = (r_op1 == OP_TURN) &&
                      ((r_ux == '0 && r_uy == '0) || (r_vx == '0 && r_vy == '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_v <= accept;
            end
            if (s2_ready) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op1 <= i_op;
            r_ux  <= n_ux;
            r_uy  <= n_uy;
            r_vx  <= n_vx;
            r_vy  <= n_vy;
        end
        if (s2_ready && r_s1_v) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_ctl <= n_ctl;
        end
    end

endmodule

>>> sv/ptad_fifo.sv
// Two-entry queue between the front end and the back end.
// Depends on no other file.
`timescale 1ns / 1ps

module ptad_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_data
);

    localparam int DEPTH = 2;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic do_push, do_pop;

    assign o_full  = (r_count == 2'(DEPTH));
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> sv/ptad_back.sv
// Back end: quadrant fold, normalization, pipelined vectoring CORDIC and
// digit-by-digit square root, then rounding and quadrant restore. Uses ptad_pkg.
`timescale 1ns / 1ps

module ptad_back
    import ptad_pkg::*;
#(
    parameter int COORD_BITS      = 8,
    parameter int ANGLE_FRAC_BITS = 6,
    parameter int DIST_FRAC_BITS  = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic signed [2*COORD_BITS+1:0]  i_x,
    input  logic signed [2*COORD_BITS+1:0]  i_y,
    input  t_ctl                            i_ctl,
    output logic                            o_valid,
    output logic signed [ANGLE_W-1:0]       o_angle_deg,
    output logic [LEN_W-1:0]                o_seg_length,
    output logic                            o_turn_left,
    output logic                            o_degenerate
);

    localparam int VW     = 2 * COORD_BITS + 2;
    localparam int NW     = NORM_BITS;
    localparam int XW     = NW + 3;
    localparam int ZW     = ATAN_W + 2;
    localparam int SH     = ZSCALE_BITS - ANGLE_FRAC_BITS;
    localparam int AGW    = ANGLE_FRAC_BITS + 9;
    localparam int QW     = AGW - 1;
    localparam int FULL   = 90 << ANGLE_FRAC_BITS;
    localparam int HALF   = 180 << ANGLE_FRAC_BITS;
    localparam int D2W    = 2 * COORD_BITS + 1;
    localparam int BW     = D2W + 2 * DIST_FRAC_BITS;
    localparam int SQ_N   = (BW + 1) / 2;
    localparam int SW     = 2 * SQ_N;
    localparam int CS     = CORDIC_STEPS;
    localparam int P_CORD = NORM_STAGES + 1;
    localparam int P_F1   = P_CORD + CS;
    localparam logic signed [AGW-1:0] HALF_A = AGW'(HALF);

    typedef struct packed {
        logic [1:0] op;
        logic       degen;
        logic       zero;
        logic       ax0;
        logic       ay0;
        logic       xneg;
        logic       yneg;
        logic       flip;
        logic       left;
    } t_flags;

    function automatic logic [2*NW-1:0] norm_pair(input logic [NW-1:0] a,
                                                  input logic [NW-1:0] b,
                                                  input int k);
        logic [NW-1:0] ta, tb, m;
        begin
            ta = a;
            tb = b;
            m  = (ta > tb) ? ta : tb;
            if ((m >> (NW - k)) == '0) begin
                ta = ta << k;
                tb = tb << k;
            end
            m = (ta > tb) ? ta : tb;
            if ((m >> (NW - k / 2)) == '0) begin
                ta = ta << (k / 2);
                tb = tb << (k / 2);
            end
            return {ta, tb};
        end
    endfunction

    logic   r_v  [P_F1+1];
    logic   n_v  [P_F1+1];
    t_flags r_fl [P_F1+1];
    t_flags n_fl [P_F1+1];
    logic [SW-1:0] r_sv [P_F1];
    logic [SW-1:0] n_sv [P_F1];
    logic [SW-1:0] r_sr [P_F1];
    logic [SW-1:0] n_sr [P_F1];
    logic [NW-1:0] r_na [NORM_STAGES+1];
    logic [NW-1:0] n_na [NORM_STAGES+1];
    logic [NW-1:0] r_nb [NORM_STAGES+1];
    logic [NW-1:0] n_nb [NORM_STAGES+1];
    logic signed [XW-1:0] r_cx [CS];
    logic signed [XW-1:0] n_cx [CS];
    logic signed [XW-1:0] r_cy [CS];
    logic signed [XW-1:0] n_cy [CS];
    logic signed [ZW-1:0] r_cz [CS];
    logic signed [ZW-1:0] n_cz [CS];

    logic [VW-1:0] abs_x, abs_y;
    logic [QW-1:0] n_q, r_q;
    logic [SW-1:0] len;
    logic [LEN_W-1:0] r_len;
    logic signed [AGW-1:0] n_ang, r_ang;
    t_flags fo;
    logic r_o_v, r_left, r_deg;
    logic [LEN_W-1:0] r_seg;

    always_comb begin
        abs_x = i_x[VW-1] ? $unsigned(-i_x) : $unsigned(i_x);
        abs_y = i_y[VW-1] ? $unsigned(-i_y) : $unsigned(i_y);
        n_v[0]        = i_valid;
        n_fl[0].op    = i_ctl.op;
        n_fl[0].degen = i_ctl.degen;
        n_fl[0].xneg  = i_x[VW-1];
        n_fl[0].ax0   = (abs_x == '0);
        n_fl[0].ay0   = (abs_y == '0);
        n_fl[0].zero  = (abs_x == '0) && (abs_y == '0);
        if (i_ctl.op == OP_TURN) begin
            n_fl[0].yneg = 1'b0;
            n_fl[0].left = (i_y > 0);
            n_fl[0].flip = !(i_y > 0);
        end else begin
            n_fl[0].yneg = i_y[VW-1];
            n_fl[0].left = 1'b0;
            n_fl[0].flip = 1'b0;
        end
        n_na[0] = NW'(abs_x);
        n_nb[0] = NW'(abs_y);
        for (int k = 1; k <= P_F1; k++) begin
            n_v[k]  = r_v[k-1];
            n_fl[k] = r_fl[k-1];
        end
        for (int g = 1; g <= NORM_STAGES; g++) begin
            {n_na[g], n_nb[g]} = norm_pair(r_na[g-1], r_nb[g-1], 32 >> (2 * (g - 1)));
        end
    end

    always_comb begin
        logic [SW-1:0] sb;
        int j;
        n_sv[0] = SW'(i_x[D2W-1:0]) << (2 * DIST_FRAC_BITS);
        n_sr[0] = '0;
        for (int k = 1; k < P_F1; k++) begin
            j  = k - P_CORD;
            sb = SW'(1) << (2 * (SQ_N - 1 - j));
            if (j >= 0 && j < SQ_N) begin
                if (r_sv[k-1] >= r_sr[k-1] + sb) begin
                    n_sv[k] = r_sv[k-1] - (r_sr[k-1] + sb);
                    n_sr[k] = (r_sr[k-1] >> 1) + sb;
                end else begin
                    n_sv[k] = r_sv[k-1];
                    n_sr[k] = r_sr[k-1] >> 1;
                end
            end else begin
                n_sv[k] = r_sv[k-1];
                n_sr[k] = r_sr[k-1];
            end
        end
    end

    always_comb begin
        logic signed [XW-1:0] cx, cy, xs, ys;
        logic signed [ZW-1:0] cz, at;
        for (int i = 0; i < CS; i++) begin
            if (i == 0) begin
                cx = XW'(r_na[NORM_STAGES]);
                cy = XW'(r_nb[NORM_STAGES]);
                cz = '0;
            end else begin
                cx = r_cx[i-1];
                cy = r_cy[i-1];
                cz = r_cz[i-1];
            end
            xs = cx >>> i;
            ys = cy >>> i;
            at = $signed(ZW'(atan_entry(5'(i))));
            if (!cy[XW-1]) begin
                n_cx[i] = cx + ys;
                n_cy[i] = cy - xs;
                n_cz[i] = cz + at;
            end else begin
                n_cx[i] = cx - ys;
                n_cy[i] = cy + xs;
                n_cz[i] = cz - at;
            end
        end
    end

    always_comb begin
        logic [ZW-1:0] zc, qr;
        zc = r_cz[CS-1][ZW-1] ? '0 : $unsigned(r_cz[CS-1]);
        qr = (zc + (ZW'(1) << (SH - 1))) >> SH;
        if (qr > ZW'(FULL)) begin
            qr = ZW'(FULL);
        end
        if (r_fl[P_F1-1].ay0) begin
            n_q = '0;
        end else if (r_fl[P_F1-1].ax0) begin
            n_q = QW'(FULL);
        end else begin
            n_q = QW'(qr);
        end
        len = r_sr[P_F1-1] + SW'(r_sv[P_F1-1] > r_sr[P_F1-1]);
    end

    always_comb begin
        fo    = r_fl[P_F1];
        n_ang = $signed({1'b0, r_q});
        if (fo.xneg) begin
            n_ang = HALF_A - n_ang;
        end
        if (fo.yneg) begin
            n_ang = -n_ang;
        end
        if (fo.flip) begin
            n_ang = -n_ang;
        end
        if (fo.zero || fo.degen || !(fo.op == OP_HEADING || fo.op == OP_TURN)) begin
            n_ang = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= P_F1; k++) begin
                r_v[k] <= 1'b0;
            end
            r_o_v  <= 1'b0;
            r_ang  <= '0;
            r_seg  <= '0;
            r_left <= 1'b0;
            r_deg  <= 1'b0;
        end else begin
            for (int k = 0; k <= P_F1; k++) begin
                r_v[k] <= n_v[k];
            end
            r_o_v  <= r_v[P_F1];
            r_ang  <= n_ang;
            r_seg  <= (fo.op == OP_DIST) ? r_len : '0;
            r_left <= (fo.op == OP_TURN) && fo.left;
            r_deg  <= (fo.op == OP_TURN) && fo.degen;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= P_F1; k++) begin
            r_fl[k] <= n_fl[k];
        end
        for (int k = 0; k < P_F1; k++) begin
            r_sv[k] <= n_sv[k];
            r_sr[k] <= n_sr[k];
        end
        for (int g = 0; g <= NORM_STAGES; g++) begin
            r_na[g] <= n_na[g];
            r_nb[g] <= n_nb[g];
        end
        for (int i = 0; i < CS; i++) begin
            r_cx[i] <= n_cx[i];
            r_cy[i] <= n_cy[i];
            r_cz[i] <= n_cz[i];
        end
        r_q   <= n_q;
        r_len <= LEN_W'(len);
    end

    assign o_valid      = r_o_v;
    assign o_angle_deg  = ANGLE_W'(r_ang);
    assign o_seg_length = r_seg;
    assign o_turn_left  = r_left;
    assign o_degenerate = r_deg;

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_deg |-> (r_ang == '0 && !r_left))
        else $error("degenerate turn with nonzero angle or left flag");

    a_dist_no_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg != '0 |-> (r_ang == '0 && !r_left && !r_deg))
        else $error("distance result carries angle fields");

    a_left_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left |-> !r_ang[AGW-1])
        else $error("left turn with negative angle");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v |-> (r_ang <= HALF_A && r_ang >= -HALF_A))
        else $error("angle beyond half turn");

endmodule

>>> sv/path_turn_angle_and_distance_unit.sv
// Top level of the path turn angle and distance unit.
// Connects ptad_front, ptad_fifo and ptad_back; uses ptad_pkg.
//
// A transaction is taken at a rising edge where start is high and busy is low.
// It carries an operation code and three points A, B and C. Op 0 returns the
// heading of A to B, op 1 the signed turn at B, op 2 the distance B to C; op 3
// returns all zero fields. Angles are in 1/64 degree, distances in 1/16 unit.
// Every transaction gives exactly one result, shown for one cycle with o_valid
// high; the receiver cannot hold it off.
// The result passes through two front stages, the queue, sign fold, three
// normalization stages, 27 CORDIC stages and two rounding and output stages.
// The square root runs one digit per stage alongside the CORDIC stages.
// Throughput is one transaction per cycle; busy rises only if the queue
// between front and back fills, which the back end, never stalling, prevents.
// Reset is synchronous and empties all stages and the queue; no result is
// shown until a new transaction has passed through.
`timescale 1ns / 1ps

module path_turn_angle_and_distance_unit
    import ptad_pkg::*;
#(
    parameter int COORD_BITS      = 8,
    parameter int ANGLE_FRAC_BITS = 6,
    parameter int DIST_FRAC_BITS  = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_op,
    input  logic signed [COORD_BITS-1:0]  i_a_x,
    input  logic signed [COORD_BITS-1:0]  i_a_y,
    input  logic signed [COORD_BITS-1:0]  i_b_x,
    input  logic signed [COORD_BITS-1:0]  i_b_y,
    input  logic signed [COORD_BITS-1:0]  i_c_x,
    input  logic signed [COORD_BITS-1:0]  i_c_y,
    output logic                          o_valid,
    output logic signed [ANGLE_W-1:0]     o_angle_deg,
    output logic [LEN_W-1:0]              o_seg_length,
    output logic                          o_turn_left,
    output logic                          o_degenerate
);

    localparam int VW     = 2 * COORD_BITS + 2;
    localparam int DATA_W = $bits(t_ctl) + 2 * VW;

    logic f_push, q_full, q_empty;
    logic signed [VW-1:0] f_x, f_y, b_x, b_y;
    t_ctl f_ctl, b_ctl;
    logic [DATA_W-1:0] q_data;

    ptad_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_op    (i_op),
        .i_a_x   (i_a_x),
        .i_a_y   (i_a_y),
        .i_b_x   (i_b_x),
        .i_b_y   (i_b_y),
        .i_c_x   (i_c_x),
        .i_c_y   (i_c_y),
        .i_full  (q_full),
        .o_push  (f_push),
        .o_x     (f_x),
        .o_y     (f_y),
        .o_ctl   (f_ctl)
    );

    ptad_fifo #(
        .DATA_W(DATA_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_ctl, f_x, f_y}),
        .o_full  (q_full),
        .i_pop   (!q_empty),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    assign {b_ctl, b_x, b_y} = q_data;

    ptad_back #(
        .COORD_BITS      (COORD_BITS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .DIST_FRAC_BITS  (DIST_FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (!q_empty),
        .i_x          (b_x),
        .i_y          (b_y),
        .i_ctl        (b_ctl),
        .o_valid      (o_valid),
        .o_angle_deg  (o_angle_deg),
        .o_seg_length (o_seg_length),
        .o_turn_left  (o_turn_left),
        .o_degenerate (o_degenerate)
    );

endmodule

>>> tb/path_turn_angle_and_distance_unit_test.sv
// Testbench of the path turn angle and distance unit: directed and random
// point triples, every result checked against an in-bench CORDIC predictor.
// Depends on ptad_pkg and path_turn_angle_and_distance_unit.
`timescale 1ns / 1ps

module path_turn_angle_and_distance_unit_test;
    import ptad_pkg::*;

    localparam int  LATENCY   = 36;
    localparam int  LIMIT     = 200000;
    localparam int  ANG_SCALE = 64;

    typedef struct {
        logic signed [ANGLE_W-1:0] angle;
        logic [LEN_W-1:0]          length;
        logic                      left;
        logic                      degen;
    } t_geom;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] i_op;
    logic signed [7:0] i_a_x, i_a_y, i_b_x, i_b_y, i_c_x, i_c_y;
    logic       o_valid;
    logic signed [ANGLE_W-1:0] o_angle_deg;
    logic [LEN_W-1:0] o_seg_length;
    logic       o_turn_left;
    logic       o_degenerate;

    t_geom expected_geom[$];
    int    fail_count;
    int    cycle_count;
    int    send_idle_pct;

    path_turn_angle_and_distance_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(i_op), .i_a_x(i_a_x), .i_a_y(i_a_y), .i_b_x(i_b_x),
        .i_b_y(i_b_y), .i_c_x(i_c_x), .i_c_y(i_c_y), .o_valid(o_valid),
        .o_angle_deg(o_angle_deg), .o_seg_length(o_seg_length),
        .o_turn_left(o_turn_left), .o_degenerate(o_degenerate)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_step(int i);
        longint t[27] = '{47185920, 27855475, 14718068, 7471121, 3750058,
            1876857, 938658, 469357, 234682, 117342, 58671, 29335, 14668,
            7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
        return t[i];
    endfunction

    function automatic longint first_quadrant_angle(longint ux, longint uy);
        longint full;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint q;
        full = 90 * ANG_SCALE;
        if (uy == 0) return 0;
        if (ux == 0) return full;
        x = ux;
        y = uy;
        while (x < (64'sd1 <<< 40) && y < (64'sd1 <<< 40)) begin
            x = x <<< 1;
            y = y <<< 1;
        end
        z = 0;
        for (int i = 0; i < 27; i++) begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_step(i);
            end else begin
                x -= ys; y += xs; z -= atan_step(i);
            end
        end
        if (z < 0) z = 0;
        q = (z + (64'sd1 <<< 13)) >>> 14;
        return (q > full) ? full : q;
    endfunction

    function automatic longint heading_of(longint x, longint y);
        longint q;
        if (x == 0 && y == 0) return 0;
        q = first_quadrant_angle(x < 0 ? -x : x, y < 0 ? -y : y);
        if (x < 0) q = 180 * ANG_SCALE - q;
        return (y < 0) ? -q : q;
    endfunction

    function automatic longint round_distance(longint d2);
        longint big;
        longint s;
        big = d2 <<< 8;
        s = 0;
        while ((s + 1) * (s + 1) <= big) s++;
        if (big > s * s + s) s++;
        return s;
    endfunction

    function automatic t_geom predict_geometry(logic [1:0] op, logic signed [7:0] ax,
            logic signed [7:0] ay, logic signed [7:0] bx, logic signed [7:0] by,
            logic signed [7:0] cx, logic signed [7:0] cy);
        t_geom r;
        longint ux, uy, vx, vy, cr, dt, ang;
        r = '{default: '0};
        ux = bx - ax; uy = by - ay; vx = cx - bx; vy = cy - by;
        ang = 0;
        if (op == OP_HEADING) begin
            ang = heading_of(ux, uy);
        end else if (op == OP_TURN) begin
            if ((ux == 0 && uy == 0) || (vx == 0 && vy == 0)) begin
                r.degen = 1'b1;
            end else begin
                cr = ux * vy - uy * vx;
                dt = ux * vx + uy * vy;
                ang = heading_of(dt, cr < 0 ? -cr : cr);
                if (cr > 0) r.left = 1'b1;
                else ang = -ang;
            end
        end else if (op == OP_DIST) begin
            r.length = LEN_W'(round_distance(vx * vx + vy * vy));
        end
        r.angle = ang[ANGLE_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_geom e;
        if (i_rst_n && o_valid) begin
            if (expected_geom.size() == 0) begin
                $display("%0t unexpected result angle %0d length %0d", $time,
                         o_angle_deg, o_seg_length);
                fail_count++;
            end else begin
                e = expected_geom.pop_front();
                if (o_angle_deg !== e.angle || o_seg_length !== e.length ||
                        o_turn_left !== e.left || o_degenerate !== e.degen) begin
                    $display("%0t mismatch expected %0d/%0d/%0b/%0b actual %0d/%0d/%0b/%0b",
                             $time, e.angle, e.length, e.left, e.degen, o_angle_deg,
                             o_seg_length, o_turn_left, o_degenerate);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_points(logic [1:0] op, logic [7:0] ax, logic [7:0] ay,
            logic [7:0] bx, logic [7:0] by, logic [7:0] cx, logic [7:0] cy);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_op <= op; i_a_x <= ax; i_a_y <= ay; i_b_x <= bx; i_b_y <= by;
        i_c_x <= cx; i_c_y <= cy;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        expected_geom.push_back(predict_geometry(op, ax, ay, bx, by, cx, cy));
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (expected_geom.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_points(OP_HEADING, 0, 0, 0, 0, 0, 0);
        send_points(OP_HEADING, 8'h80, 8'h80, 8'h7f, 8'h7f, 0, 0);
        send_points(OP_HEADING, 8'h7f, 8'h7f, 8'h80, 8'h80, 0, 0);
        send_points(OP_HEADING, 0, 0, 8'h80, 0, 0, 0);
        send_points(OP_HEADING, 0, 0, 0, 8'h7f, 0, 0);
        send_points(OP_HEADING, 0, 0, 0, 8'h80, 0, 0);
        send_points(OP_HEADING, 0, 0, 8'hfb, 8'h03, 0, 0);
        send_points(OP_TURN, 0, 0, 5, 5, 10, 10);
        send_points(OP_TURN, 0, 0, 5, 0, 0, 0);
        send_points(OP_TURN, 0, 0, 0, 0, 3, 4);
        send_points(OP_TURN, 1, 1, 4, 4, 4, 4);
        send_points(OP_TURN, 0, 0, 5, 0, 5, 5);
        send_points(OP_TURN, 0, 0, 5, 0, 5, 8'hfb);
        send_points(OP_TURN, 8'h80, 8'h80, 8'h7f, 8'h7f, 8'h80, 8'h7f);
        send_points(OP_DIST, 0, 0, 8'h80, 8'h80, 8'h7f, 8'h7f);
        send_points(OP_DIST, 0, 0, 3, 3, 3, 3);
        send_points(OP_DIST, 0, 0, 0, 0, 3, 4);
        send_points(OP_DIST, 0, 0, 8'h7f, 8'h80, 8'h80, 8'h7f);
        send_points(OP_NOP, 8'h55, 8'haa, 1, 2, 3, 4);
        drain_results();
    endtask

    task automatic test_random(int count);
        logic [7:0] bx, by;
        for (int n = 0; n < count; n++) begin
            bx = 8'($urandom);
            by = 8'($urandom);
            if ($urandom_range(3) == 0)
                send_points(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom), 8'($urandom), 8'($urandom));
            else
                send_points(2'($urandom_range(2)), 8'(bx + $urandom_range(8) - 4),
                            8'(by + $urandom_range(8) - 4), bx, by,
                            8'(bx + $urandom_range(8) - 4), 8'(by + $urandom_range(8) - 4));
        end
    endtask

    initial begin
        fail_count = 0;
        cycle_count = 0;
        send_idle_pct = 17;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_op = '0;
        {i_a_x, i_a_y, i_b_x, i_b_y, i_c_x, i_c_y} = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(700);
        drain_results();
        send_idle_pct = 65;
        test_random(650);
        send_idle_pct = 0;
        test_random(650);
        drain_results();
        repeat (LATENCY + 5) @(negedge i_clk);
        if (fail_count == 0 && expected_geom.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
